### design/bls_pkg.sv
`default_nettype none

package bls_pkg;

    // Default strip geometry and tail length.
    localparam int LED_COUNT_DEF = 10;
    localparam int TAIL_LEN_DEF  = 4;

    // Field widths of the channels and the configuration register.
    localparam int PEAK_W  = 8;
    localparam int INDEX_W = 6;
    localparam int RED_W   = 8;
    localparam int TPF_W   = 8;

    // Reset value of ticks_per_frame.
    localparam logic [TPF_W-1:0] TPF_RESET = 8'd6;

    // Depth of the job queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Fraction bits of the reciprocal used to divide the peak by the tail length.
    localparam int RECIP_SHIFT = 16;

    // One frame to render, as handed from the front part to the back part.
    typedef struct packed {
        logic [PEAK_W-1:0]  peak;
        logic [PEAK_W-1:0]  step;
        logic [INDEX_W-1:0] head;
        logic               up;
    } bls_job_t;

endpackage

`default_nettype wire

### design/bls_if.sv
`default_nettype none

// Tick channel: one request carries the peak brightness for one tick.
interface bls_tick_if import bls_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PEAK_W-1:0] peak_brightness;

    modport source (output valid, output peak_brightness, input ready);
    modport sink   (input valid, input peak_brightness, output ready);
endinterface

// LED channel: one request carries the red level of one LED.
interface bls_led_if import bls_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] led_index;
    logic [RED_W-1:0]   red_level;
    logic               last_led;

    modport source (output valid, output led_index, output red_level, output last_led,
                    input ready);
    modport sink   (input valid, input led_index, input red_level, input last_led,
                    output ready);
endinterface

`default_nettype wire

### design/bls_front.sv
`default_nettype none

module bls_front import bls_pkg::*; #(
    parameter int LED_COUNT = LED_COUNT_DEF,
    parameter int TAIL_LEN  = TAIL_LEN_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    bls_tick_if.sink              tick,
    input  wire logic             cfg_we,
    input  wire logic [TPF_W-1:0] cfg_wdata,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output bls_job_t              push_job
);

    localparam int PROD_W = PEAK_W + RECIP_SHIFT + 1;
    localparam logic [PROD_W-1:0] RECIP =
        PROD_W'(((1 << RECIP_SHIFT) + TAIL_LEN - 1) / TAIL_LEN);
    localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'(LED_COUNT - 1);

    logic [TPF_W-1:0]   tpf_reg;
    logic [TPF_W-1:0]   tick_count_reg, tick_count_next;
    logic [INDEX_W-1:0] head_reg, head_next;
    logic               up_reg, up_next;

    logic               render_now;
    logic               accept;
    logic [INDEX_W-1:0] head_moved;
    logic [PROD_W-1:0]  step_prod;

    // A tick renders once the count has reached the configured frame length.
    assign render_now = (tick_count_reg >= tpf_reg);

    // A tick that renders nothing never waits for the queue.
    assign tick.ready = push_ready || !render_now;
    assign accept     = tick.valid && tick.ready;

    // Peak divided by the tail length, by multiplying with a rounded-up reciprocal.
    assign step_prod = PROD_W'(tick.peak_brightness) * RECIP;

    assign push_valid    = tick.valid && render_now;
    assign push_job.peak = tick.peak_brightness;
    assign push_job.step = step_prod[RECIP_SHIFT +: PEAK_W];
    assign push_job.head = head_reg;
    assign push_job.up   = up_reg;

    // Head movement after a frame, reversing when it lands on either end.
    always_comb
    begin
        head_moved      = up_reg ? head_reg + 1'b1 : head_reg - 1'b1;
        tick_count_next = tick_count_reg + 1'b1;
        head_next       = head_reg;
        up_next         = up_reg;
        if (render_now)
        begin
            tick_count_next = TPF_W'(1);
            head_next       = head_moved;
            if (head_moved == LAST_IDX || head_moved == '0)
            begin
                up_next = !up_reg;
            end
        end
    end

    // Animation state and the frame-length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpf_reg        <= TPF_RESET;
            tick_count_reg <= '0;
            head_reg       <= '0;
            up_reg         <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                tpf_reg <= cfg_wdata;
            end
            if (accept)
            begin
                tick_count_reg <= tick_count_next;
                head_reg       <= head_next;
                up_reg         <= up_next;
            end
        end
    end

    // The head never leaves the strip.
    assert property (@(posedge clk) disable iff (!rst_n) head_reg <= LAST_IDX)
        else $error("head position beyond the strip");

    // A rendering tick is only taken together with its frame job.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && render_now |-> push_valid && push_ready)
        else $error("rendering tick accepted without a queued frame");

endmodule

`default_nettype wire

### design/bls_queue.sv
`default_nettype none

module bls_queue import bls_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire bls_job_t push_job,
    output logic          pop_valid,
    input  wire logic     pop_ready,
    output bls_job_t      pop_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    bls_job_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count stay consistent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == FULL_CNT) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with the fill count");

endmodule

`default_nettype wire

### design/bls_back.sv
`default_nettype none

module bls_back import bls_pkg::*; #(
    parameter int LED_COUNT = LED_COUNT_DEF,
    parameter int TAIL_LEN  = TAIL_LEN_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     pop_valid,
    output logic          pop_ready,
    input  wire bls_job_t pop_job,
    bls_led_if.source     led
);

    localparam int DIST_W = INDEX_W + 1;
    localparam int MUL_W  = 4 + PEAK_W;
    localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'(LED_COUNT - 1);
    localparam logic [DIST_W-1:0]  TOP_D    = DIST_W'(LED_COUNT - 1);
    localparam logic [DIST_W-1:0]  TAIL_D   = DIST_W'(TAIL_LEN);

    logic               busy_reg, busy_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    bls_job_t           job_reg;
    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] out_index_reg;
    logic [RED_W-1:0]   out_red_reg;
    logic               out_last_reg;

    logic               adv;
    logic               is_last;
    logic               emit;
    logic               take_job;
    logic [DIST_W-1:0]  i_d;
    logic [DIST_W-1:0]  p_d;
    logic [DIST_W-1:0]  tail_dist;
    logic               in_tail;
    logic [MUL_W-1:0]   fall;
    logic [RED_W-1:0]   red;

    // The output register moves when it is empty or being taken.
    assign adv      = !out_valid_reg || led.ready;
    assign is_last  = (idx_reg == LAST_IDX);
    assign emit     = busy_reg && adv;
    assign pop_ready = !busy_reg || (adv && is_last);
    assign take_job = pop_valid && pop_ready;

    // Distance behind the head, with the tail reflected at the strip ends.
    assign i_d = DIST_W'(idx_reg);
    assign p_d = DIST_W'(job_reg.head);

    always_comb
    begin
        if (job_reg.up)
        begin
            tail_dist = (i_d > p_d) ? i_d + p_d : p_d - i_d;
        end
        else
        begin
            tail_dist = (i_d < p_d) ? (TOP_D - p_d) + (TOP_D - i_d) : i_d - p_d;
        end
    end

    // Brightness falls by one step per place behind the head.
    assign in_tail = (tail_dist <= TAIL_D);
    assign fall    = MUL_W'(tail_dist[3:0]) * MUL_W'(job_reg.step);
    assign red     = in_tail ? job_reg.peak - fall[RED_W-1:0] : '0;

    // LED sweep control.
    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 1'b1;
            if (is_last)
            begin
                busy_next = 1'b0;
                idx_next  = '0;
            end
        end
        else if (adv)
        begin
            out_valid_next = 1'b0;
        end
        if (take_job)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Job and result payload registers.
    always_ff @(posedge clk)
    begin
        if (take_job)
        begin
            job_reg <= pop_job;
        end
        if (emit)
        begin
            out_index_reg <= idx_reg;
            out_red_reg   <= red;
            out_last_reg  <= is_last;
        end
    end

    assign led.valid     = out_valid_reg;
    assign led.led_index = out_index_reg;
    assign led.red_level = out_red_reg;
    assign led.last_led  = out_last_reg;

    // The sweep index stays on the strip.
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> idx_reg <= LAST_IDX)
        else $error("LED index beyond the strip");

    // The frame marker sits exactly on the final LED.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == (out_index_reg == LAST_IDX)))
        else $error("last_led does not match the final LED");

    // A new frame starts at LED zero only after the previous one finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        take_job && busy_reg |-> emit && is_last)
        else $error("frame job taken in the middle of a sweep");

endmodule

`default_nettype wire

### design/bouncing_led_scanner.sv
// Bouncing red scanner for an LED strip.
//
// The tick channel carries one request per animation tick with the peak
// brightness of the head. The led channel returns one request per LED,
// in index order, when a tick renders a frame; last_led marks the final LED.
// A tick renders when the tick count has reached ticks_per_frame; the user
// must write it through cfg_we and cfg_wdata only while idle; not enforced.
//
// A tick that renders nothing never waits for the queue. A rendering tick is
// queued as a frame job, taken into the back part's job register, and its LEDs
// leave through the LED output register, one LED per cycle while the receiver
// does not stall, from the single sweep unit in the back part. Up to two frame
// jobs wait in the queue, so ticks keep being accepted while a frame streams
// out. When the receiver stalls, the LED output register holds and the sweep
// pauses; ticks stall only when a rendering tick finds the queue full. Reset
// clears the tick count, puts the head on LED zero moving up, sets
// ticks_per_frame to six and empties the queue and the output.
`default_nettype none

module bouncing_led_scanner import bls_pkg::*; #(
    parameter int LED_COUNT = LED_COUNT_DEF,
    parameter int TAIL_LEN  = TAIL_LEN_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    bls_tick_if.sink              tick,
    bls_led_if.source             led,
    input  wire logic             cfg_we,
    input  wire logic [TPF_W-1:0] cfg_wdata
);

    logic     push_valid;
    logic     push_ready;
    bls_job_t push_job;
    logic     pop_valid;
    logic     pop_ready;
    bls_job_t pop_job;

    // Front part: tick counting, head movement and frame jobs.
    bls_front #(
        .LED_COUNT (LED_COUNT),
        .TAIL_LEN  (TAIL_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // Frame job queue.
    bls_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Back part: per-LED sweep and output register.
    bls_back #(
        .LED_COUNT (LED_COUNT),
        .TAIL_LEN  (TAIL_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .led       (led)
    );

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb import bls_pkg::*; ();

    localparam int LEDS     = LED_COUNT_DEF;
    localparam int TAIL     = TAIL_LEN_DEF;
    // LEDs stream one per cycle while the receiver does not stall.
    localparam int SETTLE   = 2 * LEDS + 8;
    localparam int STALL_LIMIT = 2000;

    // One expected LED request.
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [RED_W-1:0]   red;
        logic               last;
    } led_value_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [TPF_W-1:0] cfg_wdata;

    bls_tick_if tick_ch ();
    bls_led_if  led_ch ();

    bouncing_led_scanner DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .led       (led_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Scanner state as the testbench expects it.
    logic [TPF_W-1:0]   frame_period;
    logic [TPF_W-1:0]   scan_count;
    logic [INDEX_W-1:0] scan_head;
    logic               scan_up;

    led_value_t led_levels_due[$];
    led_value_t due_led;
    int mismatches;
    int send_idle_pct;
    int recv_stall_pct;
    int stall_cycles;

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Advance the scanner by one tick and queue the LED levels of a rendered frame.
    task automatic advance_scanner(input logic [PEAK_W-1:0] peak);
        int tail_dist;
        int step;
        int red;
        led_value_t lv;
        if (scan_count >= frame_period)
        begin
            scan_count = '0;
            step = int'(peak) / TAIL;
            for (int i = 0; i < LEDS; i++)
            begin
                // Distance behind the head, with the tail folded back at the ends.
                if (scan_up)
                    tail_dist = (i > int'(scan_head)) ? i + int'(scan_head)
                                                      : int'(scan_head) - i;
                else if (i < int'(scan_head))
                    tail_dist = (LEDS - 1 - int'(scan_head)) + (LEDS - 1 - i);
                else
                    tail_dist = i - int'(scan_head);
                red = (tail_dist <= TAIL) ? int'(peak) - tail_dist * step : 0;
                lv.index = i[INDEX_W-1:0];
                lv.red   = red[RED_W-1:0];
                lv.last  = (i == LEDS - 1);
                led_levels_due.push_back(lv);
            end
            // Move the head and turn around when it lands on either end.
            scan_head = scan_up ? scan_head + 1'b1 : scan_head - 1'b1;
            if (scan_head == LEDS - 1 || scan_head == 0)
                scan_up = !scan_up;
        end
        scan_count = scan_count + 1'b1;
    endtask

    // Send one tick request; valid stays high for a following request without a gap.
    task automatic send_tick(input logic [PEAK_W-1:0] peak);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid           <= 1'b1;
        tick_ch.peak_brightness <= peak;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        advance_scanner(peak);
    endtask

    // Let every frame drain out so the block is idle.
    task automatic wait_idle();
        tick_ch.valid <= 1'b0;
        while (led_levels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_period(input logic [TPF_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        frame_period = value;
    endtask

    // Reset period of six: the seventh tick renders the first frame.
    task automatic test_default_period();
        logic [PEAK_W-1:0] peaks[7] = '{8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'hFF};
        foreach (peaks[k])
            send_tick(peaks[k]);
        wait_idle();
    endtask

    // A period of zero renders on every tick; the head runs into the top end.
    task automatic test_every_tick_sweep();
        logic [PEAK_W-1:0] peaks[10] =
            '{8'd0, 8'd255, 8'd3, 8'd4, 8'd7, 8'd100, 8'd200, 8'd254, 8'd1, 8'd128};
        write_period(8'd0);
        foreach (peaks[k])
            send_tick(peaks[k]);
        wait_idle();
    endtask

    // Lowering the period below the running count renders on the next tick.
    task automatic test_lowered_period();
        write_period(8'd255);
        repeat (5) send_tick(PEAK_W'($urandom_range(0, 255)));
        wait_idle();
        write_period(8'd2);
        send_tick(8'd255);
        wait_idle();
    endtask

    // Random ticks under one period and one idling pattern.
    task automatic test_random_ticks(input int count, input int send_pct, input int recv_pct,
                                     input logic [TPF_W-1:0] period);
        int kind;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        write_period(period);
        repeat (count)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                send_tick(8'd0);
            else if (kind == 1)
                send_tick(8'd255);
            else
                send_tick(PEAK_W'($urandom_range(0, 255)));
        end
        wait_idle();
    endtask

    // Receiver stalls at random.
    always @(posedge clk)
        led_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each accepted LED request with the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && led_ch.valid && led_ch.ready)
        begin
            if (led_levels_due.size() == 0)
                report_mismatch($sformatf("LED request %0d with no frame pending",
                                          led_ch.led_index));
            else
            begin
                due_led = led_levels_due.pop_front();
                if (led_ch.led_index !== due_led.index)
                    report_mismatch($sformatf("led_index expected %0d, got %0d",
                                              due_led.index, led_ch.led_index));
                if (led_ch.red_level !== due_led.red)
                    report_mismatch($sformatf("red_level of LED %0d expected %0d, got %0d",
                                              due_led.index, due_led.red, led_ch.red_level));
                if (led_ch.last_led !== due_led.last)
                    report_mismatch($sformatf("last_led of LED %0d expected %0d, got %0d",
                                              due_led.index, due_led.last, led_ch.last_led));
            end
        end
    end

    // Stop a hung run: too many cycles with no request moving on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (tick_ch.valid && tick_ch.ready) || (led_ch.valid && led_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("bouncing_led_scanner: mismatch");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        clk                     = 1'b0;
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = '0;
        tick_ch.valid           = 1'b0;
        tick_ch.peak_brightness = '0;
        led_ch.ready            = 1'b0;
        stall_cycles            = 0;
        mismatches              = 0;
        send_idle_pct           = 20;
        recv_stall_pct          = 56;
        frame_period            = TPF_RESET;
        scan_count              = '0;
        scan_head               = '0;
        scan_up                 = 1'b1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_period();
        test_every_tick_sweep();
        test_lowered_period();
        test_random_ticks(36, 20, 56, 8'd1);
        test_random_ticks(36, 56, 20, TPF_W'($urandom_range(0, 3)));
        test_random_ticks(35, 0, 0, TPF_W'($urandom_range(0, 3)));

        if (mismatches == 0)
            $display("bouncing_led_scanner: match");
        else
            $display("bouncing_led_scanner: mismatch");
        $finish;
    end

endmodule
